// ----- design/obse_pkg.sv -----
// ----------------------------------------------------------------------------
// obse_pkg: shared types and constants for the order book snapshot engine
// message codes, result codes, controller states and control structs
// ----------------------------------------------------------------------------
package obse_pkg;

  localparam int DEF_ORDER_SLOTS = 32;
  localparam int CNT_W = 6;
  localparam int SUM_W = CNT_W + 1;

  typedef enum logic [2:0] {
    OP_NEW       = 3'd0,
    OP_DELETE    = 3'd1,
    OP_MODIFY    = 3'd2,
    OP_TRADE     = 3'd3,
    OP_HEARTBEAT = 3'd4,
    OP_SNAPSHOT  = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_EXCEEDS   = 3'd2,
    ST_FULL      = 3'd3,
    ST_UNKNOWN   = 3'd4,
    ST_DUPLICATE = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_INFO   = 2'd1,
    KIND_ENTRY  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_COUNT,
    S_INFO,
    S_SCAN,
    S_EMIT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic count_step;
    logic scan_step;
    logic scan_restart;
    logic load_info;
    logic load_entry;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic in_is_snap;
    logic scan_end;
    logic book_empty;
    logic entry_last;
    logic out_free;
  } stat_t;

endpackage

// ----- design/obse_ctrl.sv -----
// ----------------------------------------------------------------------------
// obse_ctrl: sequencer of the order book snapshot engine
// steps order messages through lookup and update, snapshots through scans
// ----------------------------------------------------------------------------
module obse_ctrl import obse_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt = stat.in_is_snap ? S_COUNT : S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.out_free) begin
          cmd.exec = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_COUNT: begin
        cmd.count_step = 1'b1;
        if (stat.scan_end) state_nxt = S_INFO;
      end
      S_INFO: begin
        if (stat.out_free) begin
          cmd.load_info = 1'b1;
          if (stat.book_empty) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.scan_restart = 1'b1;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_end) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.load_entry = 1'b1;
          if (stat.entry_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.scan_restart = 1'b1;
            state_nxt = S_SCAN;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ----- design/obse_dp.sv -----
// ----------------------------------------------------------------------------
// obse_dp: order table, key lookup, snapshot scan and result register
// one slot visited per scan cycle, best entry kept in registers
// ----------------------------------------------------------------------------
module obse_dp import obse_pkg::*; #(
  parameter int ORDER_SLOTS = DEF_ORDER_SLOTS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [2:0]  in_operation,
  input  logic [31:0] in_sequence_number,
  input  logic [31:0] in_order_key,
  input  logic [7:0]  in_instrument,
  input  logic        in_side,
  input  logic [31:0] in_quantity,
  input  logic [31:0] in_price,
  input  logic [7:0]  in_order_flags,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_result_kind,
  output logic [2:0]  out_status,
  output logic [7:0]  out_instrument,
  output logic [31:0] out_order_key,
  output logic        out_side,
  output logic [31:0] out_quantity,
  output logic [31:0] out_price,
  output logic [7:0]  out_flags,
  output logic [CNT_W-1:0] out_bid_count,
  output logic [CNT_W-1:0] out_ask_count,
  output logic [31:0] out_sequence,
  output logic        out_last
);

  localparam int IDX_W = $clog2(ORDER_SLOTS);

  // slot table
  logic [ORDER_SLOTS-1:0] valid_r;
  logic [31:0] key_r   [ORDER_SLOTS];
  logic [7:0]  inst_r  [ORDER_SLOTS];
  logic        side_r  [ORDER_SLOTS];
  logic [31:0] qty_r   [ORDER_SLOTS];
  logic [31:0] price_r [ORDER_SLOTS];
  logic [7:0]  flags_r [ORDER_SLOTS];
  logic [ORDER_SLOTS-1:0] done_r;
  logic [31:0] last_seq_r;

  // captured message
  op_t         op_r;
  logic [31:0] in_order_key_r;
  logic [31:0] m_qty_r, m_price_r;
  logic [7:0]  m_inst_r, m_flags_r;
  logic        m_side_r;
  logic        hit_r, free_r;
  logic [IDX_W-1:0] hit_idx_r, free_idx_r;

  // scan state
  logic [IDX_W-1:0] scan_idx_r;
  logic [CNT_W-1:0] bid_r, ask_r, emitted_r;
  logic        best_found_r;
  logic [IDX_W-1:0] best_idx_r;
  logic [31:0] best_key_r, best_qty_r, best_price_r;
  logic [7:0]  best_flags_r;

  // result register
  logic        out_valid_r;
  logic        out_free;

  // associative lookup on the incoming key, lowest slot wins
  logic             hit_c, free_c;
  logic [IDX_W-1:0] hit_idx_c, free_idx_c;
  always_comb begin
    hit_c = 1'b0;
    free_c = 1'b0;
    hit_idx_c = '0;
    free_idx_c = '0;
    for (int i = ORDER_SLOTS - 1; i >= 0; i--) begin
      if (valid_r[i] && key_r[i] == in_order_key) begin
        hit_c = 1'b1;
        hit_idx_c = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        free_c = 1'b1;
        free_idx_c = IDX_W'(i);
      end
    end
  end

  // single table read port
  logic [IDX_W-1:0] rd_idx;
  logic        rd_valid, rd_side, rd_done;
  logic [7:0]  rd_inst, rd_flags;
  logic [31:0] rd_key, rd_qty, rd_price;
  assign rd_idx   = cmd.exec ? hit_idx_r : scan_idx_r;
  assign rd_valid = valid_r[rd_idx];
  assign rd_done  = done_r[rd_idx];
  assign rd_side  = side_r[rd_idx];
  assign rd_inst  = inst_r[rd_idx];
  assign rd_flags = flags_r[rd_idx];
  assign rd_key   = key_r[rd_idx];
  assign rd_qty   = qty_r[rd_idx];
  assign rd_price = price_r[rd_idx];

  // scan side follows the bids already emitted
  logic scan_side, sym_match, cand, better;
  assign scan_side = (emitted_r >= bid_r);
  assign sym_match = rd_valid && (rd_inst == m_inst_r);
  assign cand      = sym_match && !rd_done && (rd_side == scan_side);
  assign better    = !best_found_r ||
                     (scan_side ? (rd_price < best_price_r) : (rd_price > best_price_r));

  // trade arithmetic
  logic [31:0] trade_rem;
  logic        trade_over;
  assign trade_rem  = rd_qty - m_qty_r;
  assign trade_over = rd_qty < m_qty_r;

  logic [SUM_W-1:0] total;
  assign total = SUM_W'(bid_r) + SUM_W'(ask_r);

  // message execution result
  status_t exec_st;
  always_comb begin
    exec_st = ST_OK;
    case (op_r)
      OP_NEW: begin
        if (hit_r) exec_st = ST_DUPLICATE;
        else if (!free_r) exec_st = ST_FULL;
      end
      OP_MODIFY:    if (!hit_r) exec_st = ST_NOT_FOUND;
      OP_TRADE:     if (hit_r && trade_over) exec_st = ST_EXCEEDS;
      OP_DELETE, OP_HEARTBEAT, OP_SNAPSHOT: exec_st = ST_OK;
      default:      exec_st = ST_UNKNOWN;
    endcase
  end

  // table, valid and done bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      done_r <= '0;
      last_seq_r <= '0;
    end else begin
      if (cmd.capture) begin
        done_r <= '0;
        if (op_t'(in_operation) != OP_SNAPSHOT) last_seq_r <= in_sequence_number;
      end
      if (cmd.load_entry) done_r[best_idx_r] <= 1'b1;
      if (cmd.exec) begin
        case (op_r)
          OP_NEW: begin
            if (!hit_r && free_r) begin
              valid_r[free_idx_r] <= 1'b1;
              key_r[free_idx_r] <= in_order_key_r;
              inst_r[free_idx_r] <= m_inst_r;
              side_r[free_idx_r] <= m_side_r;
              qty_r[free_idx_r] <= m_qty_r;
              price_r[free_idx_r] <= m_price_r;
              flags_r[free_idx_r] <= m_flags_r;
            end
          end
          OP_DELETE: if (hit_r) valid_r[hit_idx_r] <= 1'b0;
          OP_MODIFY: begin
            if (hit_r) begin
              side_r[hit_idx_r] <= m_side_r;
              qty_r[hit_idx_r] <= m_qty_r;
              price_r[hit_idx_r] <= m_price_r;
              flags_r[hit_idx_r] <= m_flags_r;
            end
          end
          OP_TRADE: begin
            if (hit_r && !trade_over) begin
              qty_r[hit_idx_r] <= trade_rem;
              if (trade_rem == '0) valid_r[hit_idx_r] <= 1'b0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // captured message and lookup result
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= op_t'(in_operation);
      in_order_key_r <= in_order_key;
      m_inst_r <= in_instrument;
      m_side_r <= in_side;
      m_qty_r <= in_quantity;
      m_price_r <= in_price;
      m_flags_r <= in_order_flags;
      hit_r <= hit_c;
      free_r <= free_c;
      hit_idx_r <= hit_idx_c;
      free_idx_r <= free_idx_c;
    end
  end

  // scan counters and best entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      bid_r <= '0;
      ask_r <= '0;
      emitted_r <= '0;
      best_found_r <= 1'b0;
    end else begin
      if (cmd.capture) begin
        scan_idx_r <= '0;
        bid_r <= '0;
        ask_r <= '0;
        emitted_r <= '0;
        best_found_r <= 1'b0;
      end
      if (cmd.count_step || cmd.scan_step) scan_idx_r <= scan_idx_r + 1'b1;
      if (cmd.count_step && sym_match) begin
        if (rd_side) ask_r <= ask_r + 1'b1;
        else bid_r <= bid_r + 1'b1;
      end
      if (cmd.scan_step && cand && better) best_found_r <= 1'b1;
      if (cmd.scan_restart) begin
        scan_idx_r <= '0;
        best_found_r <= 1'b0;
      end
      if (cmd.load_entry) emitted_r <= emitted_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && cand && better) begin
      best_idx_r <= scan_idx_r;
      best_key_r <= rd_key;
      best_qty_r <= rd_qty;
      best_price_r <= rd_price;
      best_flags_r <= rd_flags;
    end
  end

  // result register
  assign out_free = !out_valid_r || out_ready;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec || cmd.load_info || cmd.load_entry) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_result_kind <= KIND_STATUS;
      out_status <= exec_st;
      out_instrument <= '0;
      out_order_key <= '0;
      out_side <= 1'b0;
      out_quantity <= '0;
      out_price <= '0;
      out_flags <= '0;
      out_bid_count <= '0;
      out_ask_count <= '0;
      out_sequence <= '0;
      out_last <= 1'b1;
    end else if (cmd.load_info) begin
      out_result_kind <= KIND_INFO;
      out_status <= ST_OK;
      out_instrument <= m_inst_r;
      out_order_key <= '0;
      out_side <= 1'b0;
      out_quantity <= '0;
      out_price <= '0;
      out_flags <= '0;
      out_bid_count <= bid_r;
      out_ask_count <= ask_r;
      out_sequence <= last_seq_r;
      out_last <= (total == '0);
    end else if (cmd.load_entry) begin
      out_result_kind <= KIND_ENTRY;
      out_status <= ST_OK;
      out_instrument <= m_inst_r;
      out_order_key <= best_key_r;
      out_side <= scan_side;
      out_quantity <= best_qty_r;
      out_price <= best_price_r;
      out_flags <= best_flags_r;
      out_bid_count <= '0;
      out_ask_count <= '0;
      out_sequence <= '0;
      out_last <= stat.entry_last;
    end
  end

  assign out_valid = out_valid_r;

  // status to controller
  assign stat.in_is_snap = (op_t'(in_operation) == OP_SNAPSHOT);
  assign stat.scan_end   = (scan_idx_r == IDX_W'(ORDER_SLOTS - 1));
  assign stat.book_empty = (total == '0);
  assign stat.entry_last = (SUM_W'(emitted_r) + 1'b1 == total);
  assign stat.out_free   = out_free;

  // a result is never loaded over one still waiting
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec || cmd.load_info || cmd.load_entry) |-> out_free)
    else $error("result loaded while output busy");

  // entries emitted never pass the counted book
  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    SUM_W'(emitted_r) <= total)
    else $error("more entries emitted than counted");

  // an entry is only emitted after a scan found a candidate
  a_entry_found: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_entry |-> best_found_r)
    else $error("entry emitted without a candidate");

endmodule

// ----- design/order_book_snapshot_engine.sv -----
// ----------------------------------------------------------------------------
// order_book_snapshot_engine: resting order table with symbol snapshots
// top level joining the sequencer and the order table datapath
// ----------------------------------------------------------------------------
// Usage:
//   in_* channel carries one market-data word per handshake (valid/ready).
//   out_* channel returns result words (valid/ready), out_last marks the
//   final word caused by an input word.
//   Order messages (new, delete, modify, trade, heartbeat, unknown) give one
//   status word; the key lookup runs in the accept cycle and the table update
//   plus status load follow once the result register is free.
//   A snapshot counts the symbol's orders in one pass over all ORDER_SLOTS
//   slots, sends the info word, then for each order scans the table once
//   more, one slot per cycle, to pick the next best price. The single table
//   read port is why each order needs its own scan.
//   One word is worked on at a time; in_ready is high only when idle.
//   A stalled receiver holds the result register and the sequencer waits.
//   Synchronous reset empties the table and clears the last sequence number.
// ----------------------------------------------------------------------------
module order_book_snapshot_engine import obse_pkg::*; #(
  parameter int ORDER_SLOTS = DEF_ORDER_SLOTS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_operation,
  input  logic [31:0] in_sequence_number,
  input  logic [31:0] in_order_key,
  input  logic [7:0]  in_instrument,
  input  logic        in_side,
  input  logic [31:0] in_quantity,
  input  logic [31:0] in_price,
  input  logic [7:0]  in_order_flags,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_result_kind,
  output logic [2:0]  out_status,
  output logic [7:0]  out_instrument,
  output logic [31:0] out_order_key,
  output logic        out_side,
  output logic [31:0] out_quantity,
  output logic [31:0] out_price,
  output logic [7:0]  out_flags,
  output logic [CNT_W-1:0] out_bid_count,
  output logic [CNT_W-1:0] out_ask_count,
  output logic [31:0] out_sequence,
  output logic        out_last
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  obse_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // order table and result register
  obse_dp #(.ORDER_SLOTS(ORDER_SLOTS)) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_operation       (in_operation),
    .in_sequence_number (in_sequence_number),
    .in_order_key       (in_order_key),
    .in_instrument      (in_instrument),
    .in_side            (in_side),
    .in_quantity        (in_quantity),
    .in_price           (in_price),
    .in_order_flags     (in_order_flags),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_kind    (out_result_kind),
    .out_status         (out_status),
    .out_instrument     (out_instrument),
    .out_order_key      (out_order_key),
    .out_side           (out_side),
    .out_quantity       (out_quantity),
    .out_price          (out_price),
    .out_flags          (out_flags),
    .out_bid_count      (out_bid_count),
    .out_ask_count      (out_ask_count),
    .out_sequence       (out_sequence),
    .out_last           (out_last)
  );

endmodule
